@@ hdl/matrix_chain_min_cost_defines.svh @@
// ----------------------------------------------------------------------------
// Matrix chain min cost: assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CHAIN_MIN_COST_DEFINES_SVH
`define MATRIX_CHAIN_MIN_COST_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define MCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MCM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCM_ASSERT(lbl, prop, msg)
`define MCM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/mcm_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix chain min cost: shared types
// Item structs, error codes and the controller to datapath command word.
// ----------------------------------------------------------------------------
package mcm_pkg;

  localparam int COST_W   = 64;
  localparam int DIM_IN_W = 16;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_TOO_FEW  = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY = 2'd2;

  typedef struct packed {
    logic [DIM_IN_W-1:0] dimension;
    logic                last_dimension;
  } in_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              saturated;
    logic [1:0]        error_code;
  } out_item_t;

  typedef struct packed {
    logic       dim_we;     // store incoming dimension
    logic       di_latch;   // capture left bounding dimension
    logic       dj_latch;   // capture right bounding dimension
    logic       split_rd;   // capture diagonal flags for this split
    logic       diag_a;     // left sub-chain is a single matrix
    logic       diag_b;     // right sub-chain is a single matrix
    logic       mul1;
    logic       mul2;
    logic       acc;
    logic       best_init;
    logic       job_init;
    logic       cost_we;
    logic       out_load;
    logic [1:0] err_code;
  } cmd_t;

endpackage

@@ hdl/mcm_datapath.sv @@
// ----------------------------------------------------------------------------
// Matrix chain min cost: datapath
// Dimension and cost memories, two-stage product, saturating sums, minimum.
// ----------------------------------------------------------------------------
module mcm_datapath #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 16,
  localparam int IDX_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1,
  localparam int DA_W  = $clog2(MAX_MATRICES + 1)
) (
  input  logic                        clk,
  input  mcm_pkg::cmd_t               cmd,
  input  logic [mcm_pkg::DIM_IN_W-1:0] in_dimension,
  input  logic [DA_W-1:0]             dim_addr,
  input  logic [IDX_W-1:0]            row_i,
  input  logic [IDX_W-1:0]            col_k,
  input  logic [IDX_W-1:0]            row_k1,
  input  logic [IDX_W-1:0]            col_j,
  output mcm_pkg::out_item_t          out_data
);

  localparam int DEPTH  = MAX_MATRICES + 1;
  localparam int CELLS  = MAX_MATRICES * MAX_MATRICES;
  localparam int CA_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int P1_W   = 2 * DIM_BITS;
  localparam int P2_W   = 3 * DIM_BITS;
  localparam int COST_W = mcm_pkg::COST_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  logic [DIM_BITS-1:0] dim_mem [DEPTH];
  logic [COST_W-1:0]   cost_mem [CELLS];

  logic [DIM_BITS-1:0] dim_rd_r;
  logic [COST_W-1:0]   ca_rd_r;
  logic [COST_W-1:0]   cb_rd_r;
  logic [DIM_BITS-1:0] di_r;
  logic [DIM_BITS-1:0] dj_r;
  logic                diag_a_r;
  logic                diag_b_r;
  logic [P1_W-1:0]     p1_r;
  logic [P2_W-1:0]     p2_r;
  logic [COST_W-1:0]   sum1_r;
  logic                ovf1_r;
  logic [COST_W-1:0]   best_r;
  logic                ovf_r;
  mcm_pkg::out_item_t  out_r;

  logic [35:0]         dim_ext;
  logic [DIM_BITS-1:0] dim_val;
  logic [CA_W-1:0]     addr_a;
  logic [CA_W-1:0]     addr_b;
  logic [CA_W-1:0]     addr_w;
  logic [COST_W-1:0]   op_a;
  logic [COST_W-1:0]   op_b;
  logic [COST_W:0]     sum1_full;
  logic [COST_W-1:0]   prod64;
  logic [COST_W:0]     sum2_full;
  logic [COST_W-1:0]   q;

  assign dim_ext = {{(36 - mcm_pkg::DIM_IN_W){1'b0}}, in_dimension};
  assign dim_val = dim_ext[DIM_BITS-1:0];

  assign addr_a = CA_W'(row_i) * CA_W'(MAX_MATRICES) + CA_W'(col_k);
  assign addr_b = CA_W'(row_k1) * CA_W'(MAX_MATRICES) + CA_W'(col_j);
  assign addr_w = CA_W'(row_i) * CA_W'(MAX_MATRICES) + CA_W'(col_j);

  always_ff @(posedge clk) begin
    if (cmd.dim_we) begin
      dim_mem[dim_addr] <= dim_val;
    end
    dim_rd_r <= dim_mem[dim_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cost_we) begin
      cost_mem[addr_w] <= best_r;
    end
    ca_rd_r <= cost_mem[addr_a];
    cb_rd_r <= cost_mem[addr_b];
  end

  // single-matrix sub-chains cost nothing and are never stored
  assign op_a      = diag_a_r ? '0 : ca_rd_r;
  assign op_b      = diag_b_r ? '0 : cb_rd_r;
  assign sum1_full = {1'b0, op_a} + {1'b0, op_b};
  assign prod64    = {{(COST_W - P2_W){1'b0}}, p2_r};
  assign sum2_full = {1'b0, sum1_r} + {1'b0, prod64};
  assign q         = sum2_full[COST_W] ? COST_MAX : sum2_full[COST_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.di_latch) begin
      di_r <= dim_rd_r;
    end
    if (cmd.dj_latch) begin
      dj_r <= dim_rd_r;
    end
    if (cmd.split_rd) begin
      diag_a_r <= cmd.diag_a;
      diag_b_r <= cmd.diag_b;
    end
    if (cmd.mul1) begin
      p1_r   <= di_r * dim_rd_r;
      sum1_r <= sum1_full[COST_W] ? COST_MAX : sum1_full[COST_W-1:0];
      ovf1_r <= sum1_full[COST_W];
    end
    if (cmd.mul2) begin
      p2_r <= p1_r * dj_r;
    end
    if (cmd.job_init) begin
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else if (cmd.best_init) begin
      best_r <= COST_MAX;
    end else if (cmd.acc) begin
      if (q < best_r) begin
        best_r <= q;
      end
      ovf_r <= ovf_r | ovf1_r | sum2_full[COST_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.err_code == mcm_pkg::ERR_OK) begin
        out_r.min_cost  <= best_r;
        out_r.saturated <= ovf_r;
      end else begin
        out_r.min_cost  <= '0;
        out_r.saturated <= 1'b0;
      end
      out_r.error_code <= cmd.err_code;
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/mcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Matrix chain min cost: controller
// Load handshake, chain length / start / split loop sequencing, result valid.
// ----------------------------------------------------------------------------
`include "matrix_chain_min_cost_defines.svh"

module mcm_ctrl #(
  parameter int MAX_MATRICES = 16,
  localparam int IDX_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1,
  localparam int DA_W  = $clog2(MAX_MATRICES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output mcm_pkg::cmd_t    cmd,
  output logic [DA_W-1:0]  dim_addr,
  output logic [IDX_W-1:0] row_i,
  output logic [IDX_W-1:0] col_k,
  output logic [IDX_W-1:0] row_k1,
  output logic [IDX_W-1:0] col_j
);

  localparam int DEPTH    = MAX_MATRICES + 1;
  localparam int TOO_MANY = MAX_MATRICES + 2;
  localparam int CNT_W    = $clog2(MAX_MATRICES + 3);
  localparam int LEN_W    = $clog2(MAX_MATRICES + 1);
  localparam int SUM_W    = LEN_W + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CELL  = 4'd1;
  localparam logic [3:0] S_CELL2 = 4'd2;
  localparam logic [3:0] S_CELL3 = 4'd3;
  localparam logic [3:0] S_SPLIT = 4'd4;
  localparam logic [3:0] S_MUL1  = 4'd5;
  localparam logic [3:0] S_MUL2  = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] m_r, m_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             accept;
  logic             out_free;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [SUM_W-1:0] j_sum;
  logic [SUM_W-1:0] k1_sum;
  logic [SUM_W-1:0] i_sum;
  logic [SUM_W-1:0] j1_sum;
  logic [IDX_W-1:0] j_w;
  logic [IDX_W-1:0] k1_w;

  assign out_free = !out_valid_r || !out_stall;
  // a last item needs the result register, others can load while it is held
  assign in_stall = (state_r != S_IDLE) || (in_last && !out_free);
  assign accept   = in_valid && !in_stall;

  assign j_sum  = SUM_W'(i_r) + SUM_W'(len_r) - SUM_W'(1);
  assign j_w    = j_sum[IDX_W-1:0];
  assign k1_sum = SUM_W'(k_r) + SUM_W'(1);
  assign k1_w   = k1_sum[IDX_W-1:0];
  assign i_sum  = SUM_W'(i_r) + SUM_W'(1);
  assign j1_sum = SUM_W'(j_w) + SUM_W'(1);

  assign cnt_inc = (count_r < CNT_W'(DEPTH)) ? count_r + CNT_W'(1) : CNT_W'(TOO_MANY);
  assign cnt_dec = cnt_inc - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    m_nxt         = m_r;
    len_nxt       = len_r;
    i_nxt         = i_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.err_code  = mcm_pkg::ERR_OK;
    dim_addr      = count_r[DA_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.dim_we = (count_r < CNT_W'(DEPTH));
          if (in_last) begin
            count_nxt = '0;
            if (cnt_inc < CNT_W'(2)) begin
              cmd.out_load  = 1'b1;
              cmd.err_code  = mcm_pkg::ERR_TOO_FEW;
              out_valid_nxt = 1'b1;
            end else if (cnt_inc > CNT_W'(DEPTH)) begin
              cmd.out_load  = 1'b1;
              cmd.err_code  = mcm_pkg::ERR_TOO_MANY;
              out_valid_nxt = 1'b1;
            end else begin
              cmd.job_init = 1'b1;
              m_nxt        = cnt_dec[LEN_W-1:0];
              len_nxt      = LEN_W'(2);
              i_nxt        = '0;
              // a single matrix costs nothing
              state_nxt    = (cnt_dec == CNT_W'(1)) ? S_DONE : S_CELL;
            end
          end else begin
            count_nxt = cnt_inc;
          end
        end
      end
      S_CELL: begin
        dim_addr  = DA_W'(i_r);
        k_nxt     = i_r;
        state_nxt = S_CELL2;
      end
      S_CELL2: begin
        dim_addr      = j1_sum[DA_W-1:0];
        cmd.di_latch  = 1'b1;
        cmd.best_init = 1'b1;
        state_nxt     = S_CELL3;
      end
      S_CELL3: begin
        cmd.dj_latch = 1'b1;
        state_nxt    = S_SPLIT;
      end
      S_SPLIT: begin
        dim_addr     = k1_sum[DA_W-1:0];
        cmd.split_rd = 1'b1;
        cmd.diag_a   = (k_r == i_r);
        cmd.diag_b   = (k1_w == j_w);
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (k1_sum < SUM_W'(j_w)) begin
          k_nxt     = k1_w;
          state_nxt = S_SPLIT;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.cost_we = 1'b1;
        if (len_r == m_r) begin
          state_nxt = S_DONE;
        end else if (i_sum + SUM_W'(len_r) <= SUM_W'(m_r)) begin
          i_nxt     = i_sum[IDX_W-1:0];
          state_nxt = S_CELL;
        end else begin
          len_nxt   = len_r + LEN_W'(1);
          i_nxt     = '0;
          state_nxt = S_CELL;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r   <= m_nxt;
    len_r <= len_nxt;
    i_r   <= i_nxt;
    k_r   <= k_nxt;
  end

  assign out_valid = out_valid_r;
  assign row_i     = i_r;
  assign col_k     = k_r;
  assign row_k1    = k1_w;
  assign col_j     = j_w;

  `MCM_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r && count_r == '0), "reset did not return controller to idle")
  `MCM_ASSERT(a_result_only_idle, out_valid_r |-> state_r == S_IDLE, "result pending during table fill")
  `MCM_ASSERT(a_last_clears_count, (accept && in_last) |=> count_r == '0, "count not cleared after last item")
  `MCM_ASSERT(a_split_in_cell, state_r == S_SPLIT |-> SUM_W'(k_r) < SUM_W'(j_w), "split point outside its cell")

endmodule

@@ hdl/matrix_chain_min_cost.sv @@
// ----------------------------------------------------------------------------
// Matrix chain min cost: top level
// Loads a chain's dimensions, fills the triangular cost table, returns the
// minimum scalar multiplication count.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one dimension per item, first the row count of the first matrix,
//           then the column count of each matrix. last_dimension ends a chain.
//   out_* : one item per chain, on the item carrying last_dimension.
//   Non-last items raise no result and are taken whenever the controller is
//   idle, even while a previous result waits on out_stall.
//   Fewer than two dimensions or more than MAX_MATRICES+1 answers at once
//   with an error code (result valid the cycle after the last item).
//   With m matrices, the table fill after the last item runs the shared split
//   loop (read, two multiplier stages, add/min) once per split point, plus
//   per-cell dimension reads and a write-back. Input is stalled during the fill.
//   Sums saturate at 2^64-1 and set saturated.
//   Reset clears the dimension count and any pending result. A result held
//   by out_stall stays unchanged; a last item is stalled until the held result is taken.
// ----------------------------------------------------------------------------
module matrix_chain_min_cost #(
  parameter int MAX_MATRICES = 16,
  parameter int DIM_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcm_pkg::out_item_t out_data
);

  localparam int IDX_W = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int DA_W  = $clog2(MAX_MATRICES + 1);

  mcm_pkg::cmd_t    cmd;
  logic [DA_W-1:0]  dim_addr;
  logic [IDX_W-1:0] row_i;
  logic [IDX_W-1:0] col_k;
  logic [IDX_W-1:0] row_k1;
  logic [IDX_W-1:0] col_j;

  mcm_ctrl #(
    .MAX_MATRICES(MAX_MATRICES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_dimension),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .dim_addr (dim_addr),
    .row_i    (row_i),
    .col_k    (col_k),
    .row_k1   (row_k1),
    .col_j    (col_j)
  );

  mcm_datapath #(
    .MAX_MATRICES(MAX_MATRICES),
    .DIM_BITS    (DIM_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .in_dimension(in_data.dimension),
    .dim_addr    (dim_addr),
    .row_i       (row_i),
    .col_k       (col_k),
    .row_k1      (row_k1),
    .col_j       (col_j),
    .out_data    (out_data)
  );

endmodule
